>>> hw/rtl/f32exp_pkg.sv
// Shared types, constants and arithmetic helpers for the binary32 exponential.
// Depends on nothing; every other file of the block uses it.
package f32exp_pkg;

   localparam int LANES    = 4;
   localparam int FMA_LAT  = 6;
   localparam int SCL_LAT  = 2;
   localparam int LANE_LAT = 6 * FMA_LAT + SCL_LAT;

   typedef logic signed [13:0] exp_type;

   localparam logic [31:0] K_MAGIC   = 32'h48C0_0000;
   localparam logic [31:0] K_NMAGIC  = 32'hC8C0_0000;
   localparam logic [31:0] K_LOG2E   = 32'h3FB8_AA3B;
   localparam logic [31:0] K_MLN2HI  = 32'hBF31_7218;
   localparam logic [31:0] K_MLN2LO  = 32'h3102_E308;
   localparam logic [31:0] K_C1      = 32'h3F80_007B;
   localparam logic [31:0] K_C2      = 32'h3F00_0000;
   localparam logic [31:0] K_ONE     = 32'h3F80_0000;
   localparam logic [31:0] K_NEGZERO = 32'h8000_0000;
   localparam logic [31:0] K_DEFNAN  = 32'hFFC0_0000;
   localparam logic [31:0] K_INF     = 32'h7F80_0000;
   localparam logic [31:0] K_QUIET   = 32'h0040_0000;
   localparam logic [31:0] K_BIGARG  = 32'h4800_0000;

   function automatic logic [31:0] pow2_tab(input logic [4:0] idx);
      logic [31:0] r;
      unique case (idx)
         5'd0:  r = 32'h3F800000;  5'd1:  r = 32'h3F82CD87;
         5'd2:  r = 32'h3F85AAC3;  5'd3:  r = 32'h3F88980F;
         5'd4:  r = 32'h3F8B95C2;  5'd5:  r = 32'h3F8EA43A;
         5'd6:  r = 32'h3F91C3D3;  5'd7:  r = 32'h3F94F4F0;
         5'd8:  r = 32'h3F9837F0;  5'd9:  r = 32'h3F9B8D3A;
         5'd10: r = 32'h3F9EF532;  5'd11: r = 32'h3FA27043;
         5'd12: r = 32'h3FA5FED7;  5'd13: r = 32'h3FA9A15B;
         5'd14: r = 32'h3FAD583F;  5'd15: r = 32'h3FB123F6;
         5'd16: r = 32'h3FB504F3;  5'd17: r = 32'h3FB8FBAF;
         5'd18: r = 32'h3FBD08A4;  5'd19: r = 32'h3FC12C4D;
         5'd20: r = 32'h3FC5672A;  5'd21: r = 32'h3FC9B9BE;
         5'd22: r = 32'h3FCE248C;  5'd23: r = 32'h3FD2A81E;
         5'd24: r = 32'h3FD744FD;  5'd25: r = 32'h3FDBFBB8;
         5'd26: r = 32'h3FE0CCDF;  5'd27: r = 32'h3FE5B907;
         5'd28: r = 32'h3FEAC0C7;  5'd29: r = 32'h3FEFE4BA;
         5'd30: r = 32'h3FF5257D;  5'd31: r = 32'h3FFA83B3;
         default: r = 32'h3F800000;
      endcase
      return r;
   endfunction

   function automatic logic is_nan(input logic [31:0] v);
      return v[30:23] == 8'hFF && v[22:0] != 23'd0;
   endfunction

   function automatic logic is_inf(input logic [31:0] v);
      return v[30:0] == K_INF[30:0];
   endfunction

   function automatic logic is_zero(input logic [31:0] v);
      return v[30:0] == 31'd0;
   endfunction

   function automatic logic [23:0] unp_m(input logic [31:0] v);
      return (v[30:23] == 8'd0) ? {1'b0, v[22:0]} : {1'b1, v[22:0]};
   endfunction

   function automatic exp_type unp_e(input logic [31:0] v);
      exp_type r;
      if (v[30:23] == 8'd0) r = -14'sd149;
      else r = $signed({6'd0, v[30:23]}) - 14'sd150;
      return r;
   endfunction

   // Position of the highest set bit plus one; zero for a zero word.
   function automatic logic [6:0] bitlen64(input logic [63:0] v);
      logic [6:0] r;
      r = 7'd0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) r = 7'(i + 1);
      end
      return r;
   endfunction

   // Round s * m * 2^e once to binary32, nearest-even; bl is the bit length of m.
   function automatic logic [31:0] pack_f(input logic s, input logic [63:0] m,
                                          input exp_type e, input logic [6:0] bl);
      exp_type sh, nsh, e2, be;
      logic [63:0] q;
      logic rb, st;
      logic [31:0] r;
      sh = $signed({7'd0, bl}) - 14'sd24;
      if (e + sh < -14'sd149) sh = -14'sd149 - e;
      rb = 1'b0;
      st = 1'b0;
      nsh = -sh;
      if (sh > 14'sd0) begin
         if (sh >= 14'sd64) begin
            q  = 64'd0;
            rb = (sh == 14'sd64) ? m[63] : 1'b0;
            st = (sh == 14'sd64) ? (m[62:0] != 63'd0) : 1'b1;
         end else begin
            q  = m >> sh[5:0];
            rb = m[sh[5:0] - 6'd1];
            st = (m & ((64'd1 << (sh[5:0] - 6'd1)) - 64'd1)) != 64'd0;
         end
         if (rb && (st || q[0])) q = q + 64'd1;
         if (q == 64'h100_0000) begin
            q  = q >> 1;
            sh = sh + 14'sd1;
         end
      end else begin
         q = m << nsh[5:0];
      end
      e2 = e + sh;
      be = e2 + 14'sd150;
      if (q >= 64'h80_0000) begin
         if (be >= 14'sd255) r = {s, K_INF[30:0]};
         else r = {s, be[7:0], q[22:0]};
      end else begin
         r = {s, q[30:0]};
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/f32exp_req_if.sv
// Request channel: valid/ready handshake carrying the lane arguments and batch mark.
// Depends on f32exp_pkg for the lane count.
interface f32exp_req_if;
   logic                                valid;
   logic                                ready;
   logic [f32exp_pkg::LANES-1:0][31:0]  x;
   logic                                last_in;

   modport source (output valid, output x, output last_in, input ready);
   modport sink   (input valid, input x, input last_in, output ready);
endinterface

>>> hw/rtl/f32exp_rsp_if.sv
// Response channel: valid/ready handshake carrying the lane results and batch mark.
// Depends on f32exp_pkg for the lane count.
interface f32exp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [f32exp_pkg::LANES-1:0][31:0]  y;
   logic                                last_out;

   modport source (output valid, output y, output last_out, input ready);
   modport sink   (input valid, input y, input last_out, output ready);
endinterface

>>> hw/rtl/f32exp_fma.sv
// Six-stage pipelined binary32 fused multiply-add, single rounding.
// Depends on f32exp_pkg (unpack, bit length and rounding helpers).
module f32exp_fma (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] a,
   input  logic [31:0] b,
   input  logic [31:0] c,
   output logic [31:0] y
);
   import f32exp_pkg::*;

   // stage 1: unpack, multiply, special operands
   logic [23:0] ma, mb, mc;
   logic        sp, sc;
   logic        spec1_in;
   logic [31:0] sv1_in;

   logic        spec1_ff, sp1_ff, sc1_ff, cz1_ff;
   logic [31:0] sv1_ff;
   logic [47:0] mp1_ff;
   logic [23:0] mc1_ff;
   exp_type     ep1_ff, ec1_ff;

   assign ma = unp_m(a);
   assign mb = unp_m(b);
   assign mc = unp_m(c);
   assign sp = a[31] ^ b[31];
   assign sc = c[31];

   always_comb begin
      spec1_in = 1'b1;
      sv1_in   = 32'd0;
      priority if (is_nan(a)) sv1_in = a | K_QUIET;
      else if (is_nan(b)) sv1_in = b | K_QUIET;
      else if (is_nan(c)) sv1_in = c | K_QUIET;
      else if ((is_inf(a) && is_zero(b)) || (is_inf(b) && is_zero(a))) sv1_in = K_DEFNAN;
      else if (is_inf(a) || is_inf(b))
         sv1_in = (is_inf(c) && sc != sp) ? K_DEFNAN : {sp, K_INF[30:0]};
      else if (is_inf(c)) sv1_in = c;
      else if (is_zero(a) || is_zero(b))
         sv1_in = is_zero(c) ? {sp & sc, 31'd0} : c;
      else spec1_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         spec1_ff <= spec1_in;
         sv1_ff   <= sv1_in;
         mp1_ff   <= ma * mb;
         ep1_ff   <= unp_e(a) + unp_e(b);
         mc1_ff   <= mc;
         ec1_ff   <= unp_e(c);
         sp1_ff   <= sp;
         sc1_ff   <= sc;
         cz1_ff   <= is_zero(c);
      end
   end

   // stage 2: leading-one search on both significands
   logic        spec2_ff, sp2_ff, sc2_ff, cz2_ff;
   logic [31:0] sv2_ff;
   logic [47:0] mp2_ff;
   logic [23:0] mc2_ff;
   exp_type     ep2_ff, ec2_ff;
   logic [6:0]  blp2_ff, blc2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         spec2_ff <= spec1_ff;
         sv2_ff   <= sv1_ff;
         mp2_ff   <= mp1_ff;
         ep2_ff   <= ep1_ff;
         mc2_ff   <= mc1_ff;
         ec2_ff   <= ec1_ff;
         sp2_ff   <= sp1_ff;
         sc2_ff   <= sc1_ff;
         cz2_ff   <= cz1_ff;
         blp2_ff  <= bitlen64({16'd0, mp1_ff});
         blc2_ff  <= bitlen64({40'd0, mc1_ff});
      end
   end

   // stage 3: normalise to bit 60, order by exponent
   logic [6:0]  kp, kc;
   logic [63:0] mpn, mcn, a3_in, b3_in;
   exp_type     epn, ecn, ea3_in, d3_in;
   logic        sa3_in, sb3_in;

   assign kp  = 7'd61 - blp2_ff;
   assign kc  = 7'd61 - blc2_ff;
   assign mpn = {16'd0, mp2_ff} << kp[5:0];
   assign epn = ep2_ff - $signed({7'd0, kp});
   assign mcn = cz2_ff ? 64'd0 : ({40'd0, mc2_ff} << kc[5:0]);
   assign ecn = ec2_ff - $signed({7'd0, kc});

   always_comb begin
      if (cz2_ff || epn >= ecn) begin
         a3_in = mpn;  ea3_in = epn;  sa3_in = sp2_ff;
         b3_in = mcn;  sb3_in = sc2_ff;
         d3_in = cz2_ff ? 14'sd0 : (epn - ecn);
      end else begin
         a3_in = mcn;  ea3_in = ecn;  sa3_in = sc2_ff;
         b3_in = mpn;  sb3_in = sp2_ff;
         d3_in = ecn - epn;
      end
   end

   logic        spec3_ff, sa3_ff, sb3_ff;
   logic [31:0] sv3_ff;
   logic [63:0] a3_ff, b3_ff;
   exp_type     ea3_ff, d3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         spec3_ff <= spec2_ff;
         sv3_ff   <= sv2_ff;
         a3_ff    <= a3_in;
         b3_ff    <= b3_in;
         ea3_ff   <= ea3_in;
         sa3_ff   <= sa3_in;
         sb3_ff   <= sb3_in;
         d3_ff    <= d3_in;
      end
   end

   // stage 4: align the smaller operand with sticky, add or subtract
   logic [63:0] bal, r4_in;
   logic        s4_in;

   always_comb begin
      if (d3_ff >= 14'sd64) bal = 64'd1;
      else if (d3_ff > 14'sd0)
         bal = (b3_ff >> d3_ff[5:0])
             | {63'd0, (b3_ff & ((64'd1 << d3_ff[5:0]) - 64'd1)) != 64'd0};
      else bal = b3_ff;
      if (sa3_ff == sb3_ff) begin
         r4_in = a3_ff + bal;  s4_in = sa3_ff;
      end else if (a3_ff >= bal) begin
         r4_in = a3_ff - bal;  s4_in = sa3_ff;
      end else begin
         r4_in = bal - a3_ff;  s4_in = sb3_ff;
      end
   end

   logic        spec4_ff, s4_ff;
   logic [31:0] sv4_ff;
   logic [63:0] r4_ff;
   exp_type     e4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         spec4_ff <= spec3_ff;
         sv4_ff   <= sv3_ff;
         r4_ff    <= r4_in;
         s4_ff    <= s4_in;
         e4_ff    <= ea3_ff;
      end
   end

   // stage 5: leading-one search on the sum
   logic        spec5_ff, s5_ff;
   logic [31:0] sv5_ff;
   logic [63:0] r5_ff;
   exp_type     e5_ff;
   logic [6:0]  bl5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         spec5_ff <= spec4_ff;
         sv5_ff   <= sv4_ff;
         r5_ff    <= r4_ff;
         s5_ff    <= s4_ff;
         e5_ff    <= e4_ff;
         bl5_ff   <= bitlen64(r4_ff);
      end
   end

   // stage 6: round and pack
   logic [31:0] y_in, y_ff;

   always_comb begin
      if (spec5_ff) y_in = sv5_ff;
      else if (r5_ff == 64'd0) y_in = 32'd0;
      else y_in = pack_f(s5_ff, r5_ff, e5_ff, bl5_ff);
   end

   always_ff @(posedge clock) begin
      if (en) y_ff <= y_in;
   end

   assign y = y_ff;
endmodule

>>> hw/rtl/f32exp_lane.sv
// One exponential lane: range reduction, table, polynomial and final scaling,
// built from seven pipelined FMA units plus a two-stage scaler.
// Depends on f32exp_pkg and f32exp_fma.
module f32exp_lane (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] x_in,
   output logic [31:0] y_out
);
   import f32exp_pkg::*;

   localparam int XD = 2 * FMA_LAT;
   localparam int LD = 4 * FMA_LAT;
   localparam int ND = 4 * FMA_LAT;
   localparam int BD = LANE_LAT;

   logic [31:0] x_ff   [XD];
   logic [31:0] l_ff   [LD];
   logic [31:0] n_ff   [ND];
   logic        byp_ff [BD];
   logic [31:0] bv_ff  [BD];

   logic [31:0] n1, n2, t1, t2, p1, tl, p, l_in, bv_in;
   logic        byp_in;

   assign byp_in = is_nan(x_in) || ({1'b0, x_in[30:0]} >= K_BIGARG);
   assign bv_in  = is_nan(x_in) ? (x_in | K_QUIET) : (x_in[31] ? 32'd0 : K_INF);
   assign l_in   = pow2_tab(n1[4:0]);

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]   <= x_in;
         l_ff[0]   <= l_in;
         n_ff[0]   <= n2;
         byp_ff[0] <= byp_in;
         bv_ff[0]  <= bv_in;
         for (int i = 1; i < XD; i++) x_ff[i] <= x_ff[i-1];
         for (int i = 1; i < LD; i++) l_ff[i] <= l_ff[i-1];
         for (int i = 1; i < ND; i++) n_ff[i] <= n_ff[i-1];
         for (int i = 1; i < BD; i++) begin
            byp_ff[i] <= byp_ff[i-1];
            bv_ff[i]  <= bv_ff[i-1];
         end
      end
   end

   f32exp_fma u_n1 (.clock, .en, .a(x_in), .b(K_LOG2E), .c(K_MAGIC), .y(n1));
   f32exp_fma u_n2 (.clock, .en, .a(n1), .b(K_ONE), .c(K_NMAGIC), .y(n2));
   f32exp_fma u_t1 (.clock, .en, .a(n2), .b(K_MLN2HI), .c(x_ff[XD-1]), .y(t1));
   f32exp_fma u_t2 (.clock, .en, .a(n_ff[FMA_LAT-1]), .b(K_MLN2LO), .c(t1), .y(t2));
   f32exp_fma u_p1 (.clock, .en, .a(t2), .b(K_C2), .c(K_C1), .y(p1));
   f32exp_fma u_tl (.clock, .en, .a(t2), .b(l_ff[3*FMA_LAT-1]), .c(K_NEGZERO), .y(tl));
   f32exp_fma u_p  (.clock, .en, .a(tl), .b(p1), .c(l_ff[LD-1]), .y(p));

   // scaler stage 1: floor(n) clamped, exponent sum, bit length
   logic [31:0] nq, sv_in;
   logic        spec_in;
   logic [23:0] mn, mpv;
   exp_type     en_e, nen;
   logic [44:0] v;
   logic        frac;
   logic [10:0] kmag;
   exp_type     kk;

   assign nq  = n_ff[ND-1];
   assign mn  = unp_m(nq);
   assign mpv = unp_m(p);
   assign en_e = unp_e(nq);
   assign nen  = -en_e;

   always_comb begin
      spec_in = 1'b1;
      sv_in   = 32'd0;
      priority if (is_nan(p)) sv_in = p | K_QUIET;
      else if (is_nan(nq)) sv_in = nq | K_QUIET;
      else if (is_inf(nq)) begin
         if (!nq[31]) sv_in = is_zero(p) ? K_DEFNAN : {p[31], K_INF[30:0]};
         else sv_in = is_inf(p) ? K_DEFNAN : {p[31], 31'd0};
      end
      else if (is_inf(p) || is_zero(p)) sv_in = p;
      else spec_in = 1'b0;

      frac = 1'b0;
      if (en_e > 14'sd20) v = 45'd1000;
      else if (en_e >= 14'sd0) v = {21'd0, mn} << en_e[4:0];
      else if (nen >= 14'sd64) begin
         v    = 45'd0;
         frac = mn != 24'd0;
      end else begin
         v    = {21'd0, mn} >> nen[5:0];
         frac = ({40'd0, mn} & ((64'd1 << nen[5:0]) - 64'd1)) != 64'd0;
      end
      if (v > 45'd1000) v = 45'd1000;
      // floor rounds a negative fractional n away from zero only
      kmag = {1'b0, v[9:0]} + {10'd0, frac & nq[31]};
      kk   = nq[31] ? -$signed({3'd0, kmag}) : $signed({3'd0, kmag});
   end

   logic        sspec_ff, ss_ff;
   logic [31:0] ssv_ff;
   logic [23:0] sm_ff;
   exp_type     se_ff;
   logic [6:0]  sbl_ff;
   logic [31:0] sy_in, sy_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sspec_ff <= spec_in;
         ssv_ff   <= sv_in;
         sm_ff    <= mpv;
         se_ff    <= unp_e(p) + kk;
         ss_ff    <= p[31];
         sbl_ff   <= bitlen64({40'd0, mpv});
      end
   end

   // scaler stage 2: single rounding
   assign sy_in = sspec_ff ? ssv_ff : pack_f(ss_ff, {40'd0, sm_ff}, se_ff, sbl_ff);

   always_ff @(posedge clock) begin
      if (en) sy_ff <= sy_in;
   end

   assign y_out = byp_ff[BD-1] ? bv_ff[BD-1] : sy_ff;
endmodule

>>> hw/rtl/float32_exp_lut32_poly2_top.sv
// Vector binary32 exp: LANES lanes side by side, results merged into one response.
// Throughput: one item per cycle; the whole pipeline holds only while a
// finished response waits and the sink is not ready.
// Reset (synchronous, active high) clears the valid and output-valid flags; data
// registers are not reset.
module float32_exp_lut32_poly2_top (
   input  logic              clock,
   input  logic              reset,
   f32exp_req_if.sink        req_ch,
   f32exp_rsp_if.source      rsp_ch
);
   import f32exp_pkg::*;

   // Advance everything whenever the output register is free or being drained.
   logic adv;
   logic out_vld_ff;
   logic [LANE_LAT-1:0] vld_ff, last_ff;
   logic [LANES-1:0][31:0] lane_y;
   logic [LANES-1:0][31:0] y_ff;
   logic last_out_ff;

   assign adv          = !out_vld_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // Lanes: one exponential core per element of the item.
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      f32exp_lane u_lane (
         .clock (clock),
         .en    (adv),
         .x_in  (req_ch.x[g]),
         .y_out (lane_y[g])
      );
   end

   // Track which pipeline slots carry a transfer, and the batch mark with them.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff     <= {vld_ff[LANE_LAT-2:0], req_ch.valid};
         out_vld_ff <= vld_ff[LANE_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         last_ff     <= {last_ff[LANE_LAT-2:0], req_ch.last_in};
         last_out_ff <= last_ff[LANE_LAT-1];
         y_ff        <= lane_y;
      end
   end

   // Merge stage: gather all lane results into one response register.
   assign rsp_ch.valid    = out_vld_ff;
   assign rsp_ch.y        = y_ff;
   assign rsp_ch.last_out = last_out_ff;

`ifndef SYNTHESIS
   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff) && $stable(lane_y))
      else $error("pipeline moved during a stall");

   a_slot_follows_req: assert property (@(posedge clock) disable iff (reset)
      adv |=> vld_ff[0] == $past(req_ch.valid))
      else $error("first slot does not track the request");

   a_out_from_pipe: assert property (@(posedge clock) disable iff (reset)
      (adv && !vld_ff[LANE_LAT-1]) |=> !rsp_ch.valid)
      else $error("response without a pipeline slot");
`endif
endmodule

>>> bench/tb_top.sv
// Self-checking bench for the four-lane binary32 exponential pipeline.
// Depends on f32exp_pkg, f32exp_req_if, f32exp_rsp_if and float32_exp_lut32_poly2_top.
`timescale 1ns / 1ps

module tb_top;
   import f32exp_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic [31:0] y [LANES];
      logic        last;
   } exp_result_type;

   localparam logic [31:0] POW2_FRAC [32] = '{
      32'h3F800000, 32'h3F82CD87, 32'h3F85AAC3, 32'h3F88980F,
      32'h3F8B95C2, 32'h3F8EA43A, 32'h3F91C3D3, 32'h3F94F4F0,
      32'h3F9837F0, 32'h3F9B8D3A, 32'h3F9EF532, 32'h3FA27043,
      32'h3FA5FED7, 32'h3FA9A15B, 32'h3FAD583F, 32'h3FB123F6,
      32'h3FB504F3, 32'h3FB8FBAF, 32'h3FBD08A4, 32'h3FC12C4D,
      32'h3FC5672A, 32'h3FC9B9BE, 32'h3FCE248C, 32'h3FD2A81E,
      32'h3FD744FD, 32'h3FDBFBB8, 32'h3FE0CCDF, 32'h3FE5B907,
      32'h3FEAC0C7, 32'h3FEFE4BA, 32'h3FF5257D, 32'h3FFA83B3};

   logic clock = 1'b0;
   logic reset = 1'b1;

   f32exp_req_if req_if ();
   f32exp_rsp_if rsp_if ();

   float32_exp_lut32_poly2_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   exp_result_type pending_results [$];
   int          errors     = 0;
   int          cycles     = 0;
   int          hold_off   = 0;   // cycles the receiver must still refuse
   bit          burst_mode = 1'b0; // no idling on either side while set, but a hold-off still wins

   // Free-running clock, 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Predictor: exact binary32 arithmetic on integer mantissas.
   // ---------------------------------------------------------------
   function automatic int bits_used(input logic [63:0] m);
      int n;
      n = 0;
      for (int i = 0; i < 64; i++) if (m[i]) n = i + 1;
      return n;
   endfunction

   function automatic bit fp_nan(input logic [31:0] v);
      return v[30:0] > K_INF[30:0];
   endfunction

   function automatic bit fp_inf(input logic [31:0] v);
      return v[30:0] == K_INF[30:0];
   endfunction

   function automatic bit fp_zero(input logic [31:0] v);
      return v[30:0] == 31'd0;
   endfunction

   function automatic void split_fp(input logic [31:0] v, output logic [63:0] m,
                                    output int e);
      if (v[30:23] == 8'd0) begin
         m = {41'd0, v[22:0]};
         e = -149;
      end else begin
         m = {40'd0, 1'b1, v[22:0]};
         e = int'(v[30:23]) - 150;
      end
   endfunction

   // Round s * m * 2^e to nearest-even binary32; sticky already in m[0].
   function automatic logic [31:0] round_fp(input logic s, input logic [63:0] m,
                                            input int e);
      int          sh;
      logic [63:0] q;
      logic        rb, st;
      if (m == 64'd0) return {s, 31'd0};
      sh = bits_used(m) - 24;
      if (e + sh < -149) sh = -149 - e;
      if (sh > 0) begin
         if (sh >= 64) begin
            q  = 64'd0;
            rb = (sh == 64) ? m[63] : 1'b0;
            st = (sh == 64) ? ((m << 1) != 64'd0) : 1'b1;
         end else begin
            q  = m >> sh;
            rb = m[sh-1];
            st = (m & ((64'd1 << (sh - 1)) - 64'd1)) != 64'd0;
         end
         if (rb && (st || q[0])) q = q + 64'd1;
         if (q == 64'h100_0000) begin
            q  = q >> 1;
            sh = sh + 1;
         end
      end else begin
         q = m << (-sh);
      end
      if (q >= 64'h80_0000) begin
         if (e + sh + 150 >= 255) return {s, K_INF[30:0]};
         return {s, 8'(e + sh + 150), q[22:0]};
      end
      return {s, 8'd0, q[22:0]};
   endfunction

   function automatic logic [31:0] fused_mac(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c);
      logic        sp, sc, sa, sb, s;
      logic [63:0] ma, mb, mc, mp, big, lit, r, lost;
      int          ea, eb, ec, ep, eb2, d, k;
      sp = a[31] ^ b[31];
      sc = c[31];
      if (fp_nan(a)) return a | K_QUIET;
      if (fp_nan(b)) return b | K_QUIET;
      if (fp_nan(c)) return c | K_QUIET;
      if ((fp_inf(a) && fp_zero(b)) || (fp_inf(b) && fp_zero(a))) return K_DEFNAN;
      if (fp_inf(a) || fp_inf(b)) begin
         if (fp_inf(c) && sc != sp) return K_DEFNAN;
         return {sp, K_INF[30:0]};
      end
      if (fp_inf(c)) return c;
      split_fp(a, ma, ea);
      split_fp(b, mb, eb);
      split_fp(c, mc, ec);
      mp = ma * mb;
      ep = ea + eb;
      if (mp == 64'd0) begin
         if (mc == 64'd0) return {sp & sc, 31'd0};
         return c;
      end
      if (mc == 64'd0) return round_fp(sp, mp, ep);
      k = 61 - bits_used(mp); mp = mp << k; ep = ep - k;
      k = 61 - bits_used(mc); mc = mc << k; ec = ec - k;
      if (ep >= ec) begin
         big = mp; eb2 = ep; sa = sp; lit = mc; sb = sc; d = ep - ec;
      end else begin
         big = mc; eb2 = ec; sa = sc; lit = mp; sb = sp; d = ec - ep;
      end
      if (d >= 64) lit = 64'd1;
      else if (d > 0) begin
         lost = lit & ((64'd1 << d) - 64'd1);
         lit  = lit >> d;
         if (lost != 64'd0) lit[0] = 1'b1;
      end
      if (sa == sb) begin r = big + lit; s = sa; end
      else if (big >= lit) begin r = big - lit; s = sa; end
      else begin r = lit - big; s = sb; end
      if (r == 64'd0) return 32'd0;
      return round_fp(s, r, eb2);
   endfunction

   // p * 2^floor(n), rounded once.
   function automatic logic [31:0] scale_pow2(input logic [31:0] p, input logic [31:0] n);
      logic [63:0] mp, mn, v;
      int          ep, en;
      longint      k;
      bit          frac;
      frac = 1'b0;
      if (fp_nan(p)) return p | K_QUIET;
      if (fp_nan(n)) return n | K_QUIET;
      if (fp_inf(n)) begin
         if (!n[31]) return fp_zero(p) ? K_DEFNAN : {p[31], K_INF[30:0]};
         return fp_inf(p) ? K_DEFNAN : {p[31], 31'd0};
      end
      if (fp_inf(p) || fp_zero(p)) return p;
      split_fp(p, mp, ep);
      split_fp(n, mn, en);
      if (en > 20) v = 64'd1000;
      else if (en >= 0) v = mn << en;
      else if (-en >= 64) begin v = 64'd0; frac = (mn != 64'd0); end
      else begin
         v    = mn >> (-en);
         frac = (mn & ((64'd1 << (-en)) - 64'd1)) != 64'd0;
      end
      if (v > 64'd1000) v = 64'd1000;
      k = n[31] ? -longint'(v + frac) : longint'(v);
      return round_fp(p[31], mp, ep + int'(k));
   endfunction

   function automatic logic [31:0] exp_of(input logic [31:0] x);
      logic [31:0] n, l, t, p, tl;
      if (fp_nan(x)) return x | K_QUIET;
      if (x[30:0] >= K_BIGARG[30:0]) return x[31] ? 32'd0 : K_INF;
      n  = fused_mac(x, K_LOG2E, K_MAGIC);
      l  = POW2_FRAC[n[4:0]];
      n  = fused_mac(n, K_ONE, K_NMAGIC);
      t  = fused_mac(n, K_MLN2HI, x);
      t  = fused_mac(n, K_MLN2LO, t);
      p  = fused_mac(t, K_C2, K_C1);
      tl = fused_mac(t, l, K_NEGZERO);
      p  = fused_mac(tl, p, l);
      return scale_pow2(p, n);
   endfunction

   // ---------------------------------------------------------------
   // Sender side.
   // ---------------------------------------------------------------
   function automatic int gap_length();
      if (burst_mode || $urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(15, 60);
      return $urandom_range(1, 4);
   endfunction

   // Offer one item, hold it until the transfer, then queue its prediction.
   task automatic send_item(input logic [31:0] xs [LANES], input logic last);
      exp_result_type want;
      int          gap;
      gap = gap_length();
      repeat (gap) begin
         @(negedge clock);
         req_if.valid = 1'b0;
      end
      @(negedge clock);
      req_if.valid   = 1'b1;
      req_if.last_in = last;
      for (int i = 0; i < LANES; i++) req_if.x[i] = xs[i];
      do @(posedge clock); while (!req_if.ready);
      for (int i = 0; i < LANES; i++) want.y[i] = exp_of(xs[i]);
      want.last = last;
      pending_results.push_back(want);
   endtask

   // Drop valid once the stream pauses.
   task automatic idle_sender();
      @(negedge clock);
      req_if.valid = 1'b0;
   endtask

   // Pick an argument: mostly the useful range, plus the edges and raw noise.
   function automatic logic [31:0] pick_arg();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v[30:23] = 8'($urandom_range(100, 133)); // |x| up to ~128
         4:          v[30:23] = 8'($urandom_range(0, 99));    // tiny, subnormal
         5: begin                                              // overflow edge
            v = 32'h42B1_7218 + 32'($urandom_range(0, 40000)) - 32'd20000;
            v[31] = 1'b0;
         end
         6: begin                                              // underflow, subnormals
            v = 32'hC2AE_AC50 + 32'($urandom_range(0, 2500000));
         end
         7:          v[30:23] = 8'($urandom_range(134, 146)); // up to and past the big-argument limit
         8:          v[30:23] = 8'($urandom_range(143, 255)); // big, inf, NaN
         default: ;
      endcase
      return v;
   endfunction

   // ---------------------------------------------------------------
   // Receiver side: random stalls, plus counted hold-offs, random or set by a test.
   // ---------------------------------------------------------------
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            rsp_if.ready = 1'b0;
            hold_off--;
         end else if (burst_mode) begin
            rsp_if.ready = 1'b1;
         end else begin
            case ($urandom_range(0, 39))
               0:          rsp_if.ready = 1'b0;
               1, 2, 3, 4: rsp_if.ready = ~rsp_if.ready;
               default:    rsp_if.ready = 1'b1;
            endcase
            if (!rsp_if.ready && $urandom_range(0, 15) == 0) hold_off = $urandom_range(5, 40);
         end
      end
   end

   task automatic report(input string what, input int lane, input logic [31:0] got,
                         input logic [31:0] want);
      $display("mismatch %s lane %0d: got %08h, expected %08h at cycle %0d",
               what, lane, got, want, cycles);
      errors++;
   endtask

   // Compare every response transfer with the oldest prediction.
   always @(posedge clock) begin
      exp_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_results.size() == 0) begin
            report("unexpected response", -1, rsp_if.y[0], 32'd0);
         end else begin
            want = pending_results.pop_front();
            for (int i = 0; i < LANES; i++)
               if (rsp_if.y[i] !== want.y[i]) report("y", i, rsp_if.y[i], want.y[i]);
            if (rsp_if.last_out !== want.last)
               report("last_out", -1, 32'(rsp_if.last_out), 32'(want.last));
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[float32_exp_lut32_poly2_top] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------
   // Special arguments: signed zeros, infinities, quiet and signalling NaNs,
   // the big-argument cut, overflow and underflow edges, subnormal inputs.
   task automatic test_special_values();
      logic [31:0] vals [24];
      logic [31:0] xs [LANES];
      vals = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
               32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001,
               32'hFFFF_FFFF, 32'h4800_0000, 32'hC800_0000, 32'h47FF_FFFF,
               32'hC7FF_FFFF, 32'h42B1_7217, 32'h42B1_7218, 32'h42B2_0000,
               32'hC2AE_AC50, 32'hC2CE_8ED0, 32'hC2D0_0000, 32'h0000_0001,
               32'h8080_0000, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h3E80_0000};
      for (int j = 0; j < 6; j++) begin
         for (int i = 0; i < LANES; i++) xs[i] = vals[j*LANES + i];
         send_item(xs, j[0]);
      end
      // Walk a pair of set bits through every lane so each low input bit toggles.
      for (int b = 0; b < 32; b += 2) begin
         for (int i = 0; i < LANES; i++) xs[i] = (32'd1 << b) | (32'd1 << (b + 1));
         send_item(xs, b[1]);
         if (b >= 24) break;
      end
      idle_sender();
   endtask

   task automatic test_random_stream(input int count);
      logic [31:0] xs [LANES];
      for (int k = 0; k < count; k++) begin
         if (k % 150 == 0) burst_mode = ($urandom_range(0, 2) == 0);
         for (int i = 0; i < LANES; i++) xs[i] = pick_arg();
         send_item(xs, ($urandom_range(0, 7) == 0));
      end
      burst_mode = 1'b0;
      idle_sender();
   endtask

   // Hold the receiver off long enough for the pipeline to fill and stall input.
   task automatic test_back_pressure();
      logic [31:0] xs [LANES];
      @(negedge clock);
      hold_off = 300;
      burst_mode = 1'b1;
      for (int k = 0; k < 100; k++) begin
         for (int i = 0; i < LANES; i++) xs[i] = pick_arg();
         send_item(xs, k[0]);
      end
      burst_mode = 1'b0;
      idle_sender();
   endtask

   initial begin
      req_if.valid   = 1'b0;
      req_if.last_in = 1'b0;
      for (int i = 0; i < LANES; i++) req_if.x[i] = 32'd0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_special_values();
      test_random_stream(350);
      test_back_pressure();
      test_random_stream(250);

      // Drain, then wait out the pipeline for any stray response.
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4 * (LANE_LAT + 1)) @(posedge clock);

      if (errors == 0) $display("[float32_exp_lut32_poly2_top] OK");
      else $display("[float32_exp_lut32_poly2_top] ERROR");
      $finish;
   end

endmodule

>>> float32_exp_lut32_poly2_top.f
hw/rtl/f32exp_pkg.sv
hw/rtl/f32exp_req_if.sv
hw/rtl/f32exp_rsp_if.sv
hw/rtl/f32exp_fma.sv
hw/rtl/f32exp_lane.sv
hw/rtl/float32_exp_lut32_poly2_top.sv
bench/tb_top.sv
